FILE: rtl/core/swarq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types and constants of the stop-and-wait ARQ sender.
// ----------------------------------------------------------------------------
package swarq_pkg;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned LEN_W     = 9;
	localparam int unsigned TICK_W    = 24;
	localparam int unsigned RETRY_W   = 4;
	localparam int unsigned RTT_W     = 25;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned APB_AW    = 3;
	localparam int unsigned APB_DW    = 32;

	localparam logic [CMD_W-1:0] CMD_CHUNK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_RETRIES = 1'b1;

	localparam logic [TICK_W-1:0]  TIMEOUT_RST = 24'd5000;
	localparam logic [RETRY_W-1:0] RETRIES_RST = 4'd3;
	localparam logic [RTT_W-1:0]   RTT_RST     = 25'd3;

	typedef struct packed {
		logic [TICK_W-1:0]  timeout_ticks;
		logic [RETRY_W-1:0] max_retries;
	} cfg_t;

	typedef struct packed {
		logic             send_now;
		logic             send_bit;
		logic             want_chunk;
		logic [RTT_W-1:0] rtt_estimate;
		logic [RTT_W-1:0] timeout_estimate;
		logic [CNT_W-1:0] bytes_acked;
		logic [CNT_W-1:0] chunks_acked;
		logic             finished;
		logic             gave_up;
	} result_t;

endpackage

FILE: rtl/core/swarq_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_cfg
// APB register file: timeout in ticks and retry limit.
// ----------------------------------------------------------------------------
module swarq_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [swarq_pkg::APB_AW-1:0]   paddr,
	input  logic [swarq_pkg::APB_DW-1:0]   pwdata,
	output logic [swarq_pkg::APB_DW-1:0]   prdata,
	output logic                           pready,
	output swarq_pkg::cfg_t                cfg
);

	logic [swarq_pkg::TICK_W-1:0]  timeout_q;
	logic [swarq_pkg::RETRY_W-1:0] retries_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= swarq_pkg::TIMEOUT_RST;
			retries_q <= swarq_pkg::RETRIES_RST;
		end else if (wr_en) begin
			case (paddr[2])
				swarq_pkg::REG_TIMEOUT: timeout_q <= pwdata[swarq_pkg::TICK_W-1:0];
				swarq_pkg::REG_RETRIES: retries_q <= pwdata[swarq_pkg::RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			swarq_pkg::REG_TIMEOUT:
				prdata = {{(swarq_pkg::APB_DW-swarq_pkg::TICK_W){1'b0}}, timeout_q};
			swarq_pkg::REG_RETRIES:
				prdata = {{(swarq_pkg::APB_DW-swarq_pkg::RETRY_W){1'b0}}, retries_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.timeout_ticks = timeout_q;
	assign cfg.max_retries   = retries_q;

endmodule

FILE: rtl/core/swarq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_core
// Sender state and per-event update; forms the result of each transfer.
// ----------------------------------------------------------------------------
module swarq_core #(
	parameter int unsigned CHUNK_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [swarq_pkg::CMD_W-1:0]   command,
	input  logic [swarq_pkg::LEN_W-1:0]   chunk_length,
	input  logic                          chunk_is_last,
	input  logic                          ack_bit,
	input  swarq_pkg::cfg_t               cfg,
	output swarq_pkg::result_t            result
);

	localparam int unsigned LEN_FULL = (1 << swarq_pkg::LEN_W) - 1;
	localparam int unsigned LEN_MAX  = (CHUNK_BYTES - 1 > LEN_FULL) ? LEN_FULL : CHUNK_BYTES - 1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_DONE,
		PH_ABORT
	} phase_t;

	phase_t                          phase_q,   phase_n;
	logic                            seq_q,     seq_n;
	logic [swarq_pkg::RETRY_W-1:0]   tir_q,     tir_n;
	logic [swarq_pkg::TICK_W-1:0]    elapsed_q, elapsed_n;
	logic [swarq_pkg::RTT_W-1:0]     rtt_q [2];
	logic [swarq_pkg::RTT_W-1:0]     rtt_n [2];
	logic [swarq_pkg::LEN_W-1:0]     len_q,     len_n;
	logic                            last_q,    last_n;
	logic [swarq_pkg::CNT_W-1:0]     bytes_q,   bytes_n;
	logic [swarq_pkg::CNT_W-1:0]     chunks_q,  chunks_n;
	logic                            send;
	logic [swarq_pkg::RTT_W:0]       rtt_sum;
	logic [swarq_pkg::TICK_W-1:0]    elapsed_inc;
	logic [swarq_pkg::TICK_W-1:0]    limit;
	logic [swarq_pkg::RETRY_W-1:0]   tir_inc;
	logic [swarq_pkg::LEN_W-1:0]     len_sat;

	always_comb begin
		phase_n   = phase_q;
		seq_n     = seq_q;
		tir_n     = tir_q;
		elapsed_n = elapsed_q;
		rtt_n     = rtt_q;
		len_n     = len_q;
		last_n    = last_q;
		bytes_n   = bytes_q;
		chunks_n  = chunks_q;
		send      = 1'b0;

		len_sat = (32'(chunk_length) > LEN_MAX) ? swarq_pkg::LEN_W'(LEN_MAX) : chunk_length;
		rtt_sum = {1'b0, rtt_q[seq_q]} + {1'b0, elapsed_q, 1'b0};
		elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
		limit   = (cfg.timeout_ticks != '0) ? cfg.timeout_ticks : swarq_pkg::TICK_W'(1);
		tir_inc = tir_q + 1'b1;

		if (command == swarq_pkg::CMD_CHUNK && phase_q == PH_IDLE) begin
			len_n     = len_sat;
			last_n    = chunk_is_last;
			elapsed_n = '0;
			tir_n     = '0;
			phase_n   = PH_WAIT;
			send      = 1'b1;
		end else if (command == swarq_pkg::CMD_ACK && phase_q == PH_WAIT) begin
			rtt_n[seq_q] = rtt_sum[swarq_pkg::RTT_W:1];
			elapsed_n    = '0;
			if (ack_bit == seq_q) begin
				seq_n    = ~seq_q;
				bytes_n  = bytes_q + swarq_pkg::CNT_W'(len_q) + 1'b1;
				chunks_n = chunks_q + 1'b1;
				tir_n    = '0;
				phase_n  = last_q ? PH_DONE : PH_IDLE;
			end
		end else if (command == swarq_pkg::CMD_TICK && phase_q == PH_WAIT) begin
			elapsed_n = elapsed_inc;
			if (elapsed_inc >= limit) begin
				tir_n     = tir_inc;
				elapsed_n = '0;
				if (tir_inc >= cfg.max_retries) begin
					phase_n = PH_ABORT;
				end else begin
					send = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			seq_q     <= 1'b0;
			tir_q     <= '0;
			elapsed_q <= '0;
			rtt_q[0]  <= swarq_pkg::RTT_RST;
			rtt_q[1]  <= swarq_pkg::RTT_RST;
			len_q     <= '0;
			last_q    <= 1'b0;
			bytes_q   <= '0;
			chunks_q  <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			seq_q     <= seq_n;
			tir_q     <= tir_n;
			elapsed_q <= elapsed_n;
			rtt_q     <= rtt_n;
			len_q     <= len_n;
			last_q    <= last_n;
			bytes_q   <= bytes_n;
			chunks_q  <= chunks_n;
		end
	end

	assign result.send_now         = send;
	assign result.send_bit         = seq_n;
	assign result.want_chunk       = (phase_n == PH_IDLE);
	assign result.rtt_estimate     = rtt_n[seq_n];
	assign result.timeout_estimate = rtt_n[seq_n];
	assign result.bytes_acked      = bytes_n;
	assign result.chunks_acked     = chunks_n;
	assign result.finished         = (phase_n == PH_DONE);
	assign result.gave_up          = (phase_n == PH_ABORT);

endmodule

FILE: rtl/core/swarq_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_out
// Result register with a skid stage between the input and output sides.
// ----------------------------------------------------------------------------
module swarq_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  swarq_pkg::result_t  din,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output swarq_pkg::result_t  dout
);

	logic                out_v_q;
	logic                skid_v_q;
	swarq_pkg::result_t  out_q;
	swarq_pkg::result_t  skid_q;
	logic                hold;

	assign hold      = out_v_q && out_stall;
	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign dout      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (hold) begin
			if (push) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (hold) begin
			if (push) begin
				skid_q <= din;
			end
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else if (push) begin
			out_q <= din;
		end
	end

endmodule

FILE: rtl/core/stop_and_wait_arq_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender
// Alternating-bit stop-and-wait sender: chunk, ack and tick events in,
// one status result out per event.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  input    | in_valid / in_stall      | command, chunk_length, chunk_is_last,
//           |                          | ack_bit
//  output   | out_valid / out_stall    | send_now .. gave_up
//  config   | psel/penable/pwrite/...  | timeout_ticks @0x0, max_retries @0x4
//
//  One event per cycle while in_stall is low; the state update is
//  combinational logic in front of the result register. in_stall rises
//  only while the skid stage holds a result behind a stalled output.
//  Reset returns the sender to idle with both estimates at 1.5 ticks.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender #(
	parameter int unsigned CHUNK_BYTES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swarq_pkg::APB_AW-1:0]  paddr,
	input  logic [swarq_pkg::APB_DW-1:0]  pwdata,
	output logic [swarq_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [swarq_pkg::CMD_W-1:0]   command,
	input  logic [swarq_pkg::LEN_W-1:0]   chunk_length,
	input  logic                          chunk_is_last,
	input  logic                          ack_bit,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          send_now,
	output logic                          send_bit,
	output logic                          want_chunk,
	output logic [swarq_pkg::RTT_W-1:0]   rtt_estimate,
	output logic [swarq_pkg::RTT_W-1:0]   timeout_estimate,
	output logic [swarq_pkg::CNT_W-1:0]   bytes_acked,
	output logic [swarq_pkg::CNT_W-1:0]   chunks_acked,
	output logic                          finished,
	output logic                          gave_up
);

	swarq_pkg::cfg_t     cfg;
	swarq_pkg::result_t  res;
	swarq_pkg::result_t  res_q;
	logic                accept;
	logic                full;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	swarq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swarq_core #(
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.command       (command),
		.chunk_length  (chunk_length),
		.chunk_is_last (chunk_is_last),
		.ack_bit       (ack_bit),
		.cfg           (cfg),
		.result        (res)
	);

	swarq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (res_q)
	);

	assign send_now         = res_q.send_now;
	assign send_bit         = res_q.send_bit;
	assign want_chunk       = res_q.want_chunk;
	assign rtt_estimate     = res_q.rtt_estimate;
	assign timeout_estimate = res_q.timeout_estimate;
	assign bytes_acked      = res_q.bytes_acked;
	assign chunks_acked     = res_q.chunks_acked;
	assign finished         = res_q.finished;
	assign gave_up          = res_q.gave_up;

endmodule
